// ===== hw/rtl/ldiff_pkg.sv =====
// Shared definitions for the line diff engine: default sizes, function codes
// and edit operation codes.
// No dependencies.
`timescale 1ns / 1ps

package ldiff_pkg;

    // Default number of lines per sequence.
    localparam int MAX_LINES_DEF = 32;

    // Width of a line identifier.
    localparam int ID_W = 32;

    // Function codes of an input transaction. The last code is unused and
    // the engine ignores it.
    localparam logic [1:0] FUNC_LOAD_OLD = 2'd0;
    localparam logic [1:0] FUNC_LOAD_NEW = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE  = 2'd2;
    localparam logic [1:0] FUNC_NONE     = 2'd3;

    // Edit operation codes of a result transaction.
    localparam logic [1:0] OP_EQUAL  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_EMPTY  = 2'd3;

    typedef logic [1:0] op_t;
    typedef logic [ID_W-1:0] line_id_t;

endpackage

// ===== hw/rtl/ldiff_cell.sv =====
// One column cell of the LCS wavefront array. It holds one new line, the
// running table value of its column and the decision bits of every row.
// Depends on ldiff_pkg.
`timescale 1ns / 1ps

module ldiff_cell #(
    parameter int MAX_LINES = ldiff_pkg::MAX_LINES_DEF,
    parameter int IW = 5,
    parameter int VW = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               clr,
    input  logic               new_we,
    input  ldiff_pkg::line_id_t new_id_in,
    input  logic               lf_vld,
    input  ldiff_pkg::line_id_t lf_id,
    input  logic [IW-1:0]      lf_row,
    input  logic [VW-1:0]      lf_val,
    input  logic [VW-1:0]      lf_prev,
    output logic               out_vld,
    output ldiff_pkg::line_id_t out_id,
    output logic [IW-1:0]      out_row,
    output logic [VW-1:0]      val,
    output logic [VW-1:0]      prev,
    input  logic [IW-1:0]      rd_row,
    output logic               rd_eq,
    output logic               rd_ins,
    output ldiff_pkg::line_id_t new_id
);
    import ldiff_pkg::*;

    line_id_t             nid_reg;
    logic                 vld_reg;
    line_id_t             id_reg;
    logic [IW-1:0]        row_reg;
    logic [VW-1:0]        val_reg;
    logic [VW-1:0]        prev_reg;
    logic [MAX_LINES-1:0] eq_bits_reg;
    logic [MAX_LINES-1:0] ins_bits_reg;

    logic                 eq;
    logic                 ins;
    logic [VW-1:0]        val_next;

    // Table recurrence for this column at the row now passing through.
    always_comb begin
        eq  = (lf_id == nid_reg);
        ins = (lf_val >= val_reg);
        if (eq) begin
            val_next = lf_prev + VW'(1);
        end else if (val_reg > lf_val) begin
            val_next = val_reg;
        end else begin
            val_next = lf_val;
        end
    end

    // The new line held by this column.
    always_ff @(posedge aclk) begin
        if (new_we) begin
            nid_reg <= new_id_in;
        end
    end

    // Row hand-off to the next column.
    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= lf_vld;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg  <= lf_id;
        row_reg <= lf_row;
    end

    // Column value; row zero is the cleared border.
    always_ff @(posedge aclk) begin
        if (clr) begin
            val_reg  <= '0;
            prev_reg <= '0;
        end else if (lf_vld) begin
            val_reg  <= val_next;
            prev_reg <= val_reg;
        end
    end

    // Decision bits kept for the backtrack.
    always_ff @(posedge aclk) begin
        if (lf_vld) begin
            eq_bits_reg[lf_row]  <= eq;
            ins_bits_reg[lf_row] <= ins;
        end
    end

    assign out_vld = vld_reg;
    assign out_id  = id_reg;
    assign out_row = row_reg;
    assign val     = val_reg;
    assign prev    = prev_reg;
    assign rd_eq   = eq_bits_reg[rd_row];
    assign rd_ins  = ins_bits_reg[rd_row];
    assign new_id  = nid_reg;

endmodule

// ===== hw/rtl/ldiff_chain.sv =====
// Row of column cells that fills the LCS table as a diagonal wavefront, with
// the read-out used by the backtrack.
// Depends on ldiff_pkg and ldiff_cell.
`timescale 1ns / 1ps

module ldiff_chain #(
    parameter int MAX_LINES = ldiff_pkg::MAX_LINES_DEF,
    parameter int IW = 5,
    parameter int VW = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                clr,
    input  logic                new_we,
    input  logic [IW-1:0]       new_idx,
    input  ldiff_pkg::line_id_t new_id_in,
    input  logic                feed_vld,
    input  ldiff_pkg::line_id_t feed_id,
    input  logic [IW-1:0]       feed_row,
    input  logic [IW-1:0]       rd_col,
    input  logic [IW-1:0]       rd_row,
    output logic                rd_eq,
    output logic                rd_ins,
    output ldiff_pkg::line_id_t rd_new_id
);
    import ldiff_pkg::*;

    logic            vld_w   [MAX_LINES+1];
    line_id_t        id_w    [MAX_LINES+1];
    logic [IW-1:0]   row_w   [MAX_LINES+1];
    logic [VW-1:0]   val_w   [MAX_LINES+1];
    logic [VW-1:0]   prev_w  [MAX_LINES+1];
    logic            eq_w    [MAX_LINES];
    logic            ins_w   [MAX_LINES];
    line_id_t        nid_w   [MAX_LINES];

    // Column zero of the table is the zero border.
    assign vld_w[0]  = feed_vld;
    assign id_w[0]   = feed_id;
    assign row_w[0]  = feed_row;
    assign val_w[0]  = '0;
    assign prev_w[0] = '0;

    for (genvar c = 0; c < MAX_LINES; c++) begin : g_cell
        ldiff_cell #(
            .MAX_LINES(MAX_LINES),
            .IW(IW),
            .VW(VW)
        ) u_cell (
            .aclk(aclk),
            .aresetn(aresetn),
            .clr(clr),
            .new_we(new_we && (new_idx == IW'(c))),
            .new_id_in(new_id_in),
            .lf_vld(vld_w[c]),
            .lf_id(id_w[c]),
            .lf_row(row_w[c]),
            .lf_val(val_w[c]),
            .lf_prev(prev_w[c]),
            .out_vld(vld_w[c+1]),
            .out_id(id_w[c+1]),
            .out_row(row_w[c+1]),
            .val(val_w[c+1]),
            .prev(prev_w[c+1]),
            .rd_row(rd_row),
            .rd_eq(eq_w[c]),
            .rd_ins(ins_w[c]),
            .new_id(nid_w[c])
        );
    end

    // Column select for the backtrack.
    assign rd_eq     = eq_w[rd_col];
    assign rd_ins    = ins_w[rd_col];
    assign rd_new_id = nid_w[rd_col];

endmodule

// ===== hw/rtl/lcs_line_diff.sv =====
// Line diff engine: LCS wavefront fill over a chain of column cells, backtrack
// into a script buffer, forward emit. Depends on ldiff_pkg and ldiff_chain.
// A compute clears the chain, fills the table, backtracks into the script buffer,
// then emits the script forward, each result after its buffer read; an empty
// compute emits one empty result. Throughput: one load per cycle while idle.
// Sync active-low reset clears counts, flags, control.
`timescale 1ns / 1ps

module lcs_line_diff #(
    parameter int MAX_LINES = ldiff_pkg::MAX_LINES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_func,
    input  ldiff_pkg::line_id_t s_line_id,
    output logic                m_valid,
    input  logic                m_ready,
    output ldiff_pkg::op_t      m_op,
    output ldiff_pkg::line_id_t m_line_out,
    output logic                m_run_start,
    output logic                m_last,
    output logic                m_overflow
);
    import ldiff_pkg::*;

    localparam int CW = $clog2(MAX_LINES + 1);
    localparam int IW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int LW = $clog2(2 * MAX_LINES + 1);
    localparam int AW = $clog2(2 * MAX_LINES);
    localparam int SD = 2 * MAX_LINES;
    localparam int EW = 2 + ID_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLR   = 3'd1;
    localparam logic [2:0] S_FILL  = 3'd2;
    localparam logic [2:0] S_BT    = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_EMPTY = 3'd5;

    logic [2:0]    state_reg;
    logic [CW-1:0] old_cnt_reg;
    logic [CW-1:0] new_cnt_reg;
    logic          ovf_reg;
    logic [CW-1:0] m_len_reg;
    logic [CW-1:0] n_len_reg;
    logic          ovf_lat_reg;
    logic [LW-1:0] fcnt_reg;
    logic [CW-1:0] bi_reg;
    logic [CW-1:0] bj_reg;
    logic [LW-1:0] len_reg;
    logic [AW-1:0] rd_addr_reg;
    logic          rd_wait_reg;
    logic [EW-1:0] rdata_reg;
    logic          first_reg;
    op_t           prev_op_reg;

    logic          out_vld_reg;
    op_t           out_op_reg;
    line_id_t      out_line_reg;
    logic          out_rs_reg;
    logic          out_last_reg;
    logic          out_ovf_reg;

    line_id_t      old_mem [MAX_LINES];
    logic [EW-1:0] sbuf_mem [SD];

    logic          s_fire;
    logic          out_free;
    logic          out_load;
    logic          i_nz;
    logic          j_nz;
    logic [IW-1:0] old_addr;
    line_id_t      old_rd;
    logic          feed_vld;
    logic          new_we;
    logic          chain_clr;
    logic          rd_eq;
    logic          rd_ins;
    line_id_t      rd_new_id;
    logic          take_eq;
    logic          take_ins;
    op_t           bt_op;
    line_id_t      bt_line;
    op_t           em_op;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !out_vld_reg || m_ready;
    assign out_load = ((state_reg == S_EMIT) && !rd_wait_reg && out_free) ||
                      ((state_reg == S_EMPTY) && out_free);
    assign i_nz     = (bi_reg != '0);
    assign j_nz     = (bj_reg != '0);

    // Old line read: fill order during the fill, row i-1 during the backtrack.
    assign old_addr = (state_reg == S_BT) ? IW'(bi_reg - CW'(1)) : fcnt_reg[IW-1:0];
    assign old_rd   = old_mem[old_addr];
    assign feed_vld = (state_reg == S_FILL) && (fcnt_reg < LW'(m_len_reg));

    assign new_we    = s_fire && (s_func == FUNC_LOAD_NEW) && (new_cnt_reg < CW'(MAX_LINES));
    assign chain_clr = (state_reg == S_CLR);

    ldiff_chain #(
        .MAX_LINES(MAX_LINES),
        .IW(IW),
        .VW(CW)
    ) u_chain (
        .aclk(aclk),
        .aresetn(aresetn),
        .clr(chain_clr),
        .new_we(new_we),
        .new_idx(new_cnt_reg[IW-1:0]),
        .new_id_in(s_line_id),
        .feed_vld(feed_vld),
        .feed_id(old_rd),
        .feed_row(fcnt_reg[IW-1:0]),
        .rd_col(IW'(bj_reg - CW'(1))),
        .rd_row(IW'(bi_reg - CW'(1))),
        .rd_eq(rd_eq),
        .rd_ins(rd_ins),
        .rd_new_id(rd_new_id)
    );

    // Backtrack step: equal pair first, insert wins a tie, else delete.
    always_comb begin
        take_eq  = i_nz && j_nz && rd_eq;
        take_ins = !take_eq && j_nz && (!i_nz || rd_ins);
        if (take_eq) begin
            bt_op   = OP_EQUAL;
            bt_line = old_rd;
        end else if (take_ins) begin
            bt_op   = OP_INSERT;
            bt_line = rd_new_id;
        end else begin
            bt_op   = OP_DELETE;
            bt_line = old_rd;
        end
    end

    assign em_op = rdata_reg[EW-1:ID_W];

    // Old line store.
    always_ff @(posedge aclk) begin
        if (s_fire && (s_func == FUNC_LOAD_OLD) && (old_cnt_reg < CW'(MAX_LINES))) begin
            old_mem[old_cnt_reg[IW-1:0]] <= s_line_id;
        end
    end

    // Script buffer, written last-first by the backtrack, read back forward.
    always_ff @(posedge aclk) begin
        if ((state_reg == S_BT) && (i_nz || j_nz)) begin
            sbuf_mem[len_reg[AW-1:0]] <= {bt_op, bt_line};
        end
        rdata_reg <= sbuf_mem[rd_addr_reg];
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if ((state_reg == S_EMIT) && !rd_wait_reg && out_free) begin
            out_op_reg   <= em_op;
            out_line_reg <= rdata_reg[ID_W-1:0];
            out_rs_reg   <= first_reg || (em_op != prev_op_reg);
            out_last_reg <= (rd_addr_reg == '0);
            out_ovf_reg  <= ovf_lat_reg;
        end else if ((state_reg == S_EMPTY) && out_free) begin
            out_op_reg   <= OP_EMPTY;
            out_line_reg <= '0;
            out_rs_reg   <= 1'b1;
            out_last_reg <= 1'b1;
            out_ovf_reg  <= ovf_lat_reg;
        end
    end

    // Result valid: set when a result is loaded, cleared when it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_load) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    // Sequencer and control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            old_cnt_reg <= '0;
            new_cnt_reg <= '0;
            ovf_reg     <= 1'b0;
            rd_wait_reg <= 1'b0;
            first_reg   <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        case (s_func)
                            FUNC_LOAD_OLD: begin
                                if (old_cnt_reg < CW'(MAX_LINES)) begin
                                    old_cnt_reg <= old_cnt_reg + CW'(1);
                                end else begin
                                    ovf_reg <= 1'b1;
                                end
                            end
                            FUNC_LOAD_NEW: begin
                                if (new_cnt_reg < CW'(MAX_LINES)) begin
                                    new_cnt_reg <= new_cnt_reg + CW'(1);
                                end else begin
                                    ovf_reg <= 1'b1;
                                end
                            end
                            FUNC_COMPUTE: begin
                                m_len_reg   <= old_cnt_reg;
                                n_len_reg   <= new_cnt_reg;
                                ovf_lat_reg <= ovf_reg;
                                old_cnt_reg <= '0;
                                new_cnt_reg <= '0;
                                ovf_reg     <= 1'b0;
                                fcnt_reg    <= '0;
                                if ((old_cnt_reg == '0) && (new_cnt_reg == '0)) begin
                                    state_reg <= S_EMPTY;
                                end else begin
                                    state_reg <= S_CLR;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    state_reg <= S_FILL;
                end
                S_FILL: begin
                    fcnt_reg <= fcnt_reg + LW'(1);
                    if (fcnt_reg == (LW'(m_len_reg) + LW'(n_len_reg))) begin
                        bi_reg    <= m_len_reg;
                        bj_reg    <= n_len_reg;
                        len_reg   <= '0;
                        state_reg <= S_BT;
                    end
                end
                S_BT: begin
                    if (i_nz || j_nz) begin
                        len_reg <= len_reg + LW'(1);
                        if (take_eq) begin
                            bi_reg <= bi_reg - CW'(1);
                            bj_reg <= bj_reg - CW'(1);
                        end else if (take_ins) begin
                            bj_reg <= bj_reg - CW'(1);
                        end else begin
                            bi_reg <= bi_reg - CW'(1);
                        end
                    end else begin
                        rd_addr_reg <= AW'(len_reg - LW'(1));
                        rd_wait_reg <= 1'b1;
                        first_reg   <= 1'b1;
                        state_reg   <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (rd_wait_reg) begin
                        rd_wait_reg <= 1'b0;
                    end else if (out_free) begin
                        prev_op_reg <= em_op;
                        first_reg   <= 1'b0;
                        if (rd_addr_reg == '0) begin
                            state_reg <= S_IDLE;
                        end else begin
                            rd_addr_reg <= rd_addr_reg - AW'(1);
                            rd_wait_reg <= 1'b1;
                        end
                    end
                end
                S_EMPTY: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = out_vld_reg;
    assign m_op        = out_op_reg;
    assign m_line_out  = out_line_reg;
    assign m_run_start = out_rs_reg;
    assign m_last      = out_last_reg;
    assign m_overflow  = out_ovf_reg;

endmodule

// ===== hw/rtl/ldiff_checker.sv =====
// Port-level checks for the line diff engine, bound to the top level.
// Depends on ldiff_pkg and lcs_line_diff.
`timescale 1ns / 1ps

module ldiff_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input ldiff_pkg::op_t      m_op,
    input ldiff_pkg::line_id_t m_line_out,
    input logic                m_run_start,
    input logic                m_last
);
    import ldiff_pkg::*;

    // A stalled result transaction keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_op) && $stable(m_line_out))
        else $error("result changed while stalled");

    // An empty script is a single transaction that starts and ends the run.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_op == OP_EMPTY) |-> m_run_start && m_last && (m_line_out == '0))
        else $error("malformed empty script result");

    // The transaction after a final one opens a new run.
    a_new_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> !m_valid || m_run_start)
        else $error("script did not restart its run");

    // No input is taken while a script is still being produced.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input accepted during a script");

endmodule

bind lcs_line_diff ldiff_checker u_ldiff_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_op(m_op),
    .m_line_out(m_line_out),
    .m_run_start(m_run_start),
    .m_last(m_last)
);

// ===== sim/lcs_line_diff_test.sv =====
// Self-checking testbench for the lcs_line_diff line diff engine.
// Drives loads and computes over valid/ready, predicts each edit script
// internally and compares every result transaction. Depends on ldiff_pkg and lcs_line_diff.
`timescale 1ns / 1ps

module lcs_line_diff_test;
    import ldiff_pkg::*;

    localparam int NLINES = 32;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        op_t      op;
        line_id_t line;
        logic     run_start;
        logic     last;
        logic     overflow;
    } edit_t;

    typedef struct {
        logic [1:0] func;
        line_id_t   line_id;
        logic       has_exp;
        edit_t      exp;
    } stim_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_func = FUNC_LOAD_OLD;
    line_id_t   s_line_id = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    op_t        m_op;
    line_id_t   m_line_out;
    logic       m_run_start;
    logic       m_last;
    logic       m_overflow;

    // Predictor state for the diff engine.
    line_id_t old_lines[NLINES];
    line_id_t new_lines[NLINES];
    int       old_len = 0;
    int       new_len = 0;
    logic     lines_dropped = 1'b0;

    edit_t     script_q[$];
    stim_row_t rows[$];
    int        errors = 0;
    int        idle_cycles = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    logic      done = 1'b0;

    lcs_line_diff DUT (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Append one row to the directed stimulus table.
    function automatic void add_row(input logic [1:0] func, input line_id_t id,
                                    input logic has_exp, input edit_t want);
        stim_row_t r;
        r.func    = func;
        r.line_id = id;
        r.has_exp = has_exp;
        r.exp     = want;
        rows = {rows, r};
    endfunction

    // Track one input transaction and build the edit script on a compute.
    task automatic predict_script(input logic [1:0] func, input line_id_t id);
        int   lcs [NLINES+1][NLINES+1];
        op_t  ops [2*NLINES];
        line_id_t ids [2*NLINES];
        int   i, j, len;
        edit_t e;
        case (func)
            FUNC_LOAD_OLD: begin
                if (old_len < NLINES) old_lines[old_len++] = id;
                else lines_dropped = 1'b1;
            end
            FUNC_LOAD_NEW: begin
                if (new_len < NLINES) new_lines[new_len++] = id;
                else lines_dropped = 1'b1;
            end
            FUNC_COMPUTE: begin
                if (old_len == 0 && new_len == 0) begin
                    e = '{OP_EMPTY, '0, 1'b1, 1'b1, lines_dropped};
                    script_q = {script_q, e};
                end else begin
                    for (i = 0; i <= old_len; i++) lcs[i][0] = 0;
                    for (j = 0; j <= new_len; j++) lcs[0][j] = 0;
                    for (i = 1; i <= old_len; i++)
                        for (j = 1; j <= new_len; j++)
                            if (old_lines[i-1] == new_lines[j-1])
                                lcs[i][j] = lcs[i-1][j-1] + 1;
                            else
                                lcs[i][j] = (lcs[i-1][j] > lcs[i][j-1]) ?
                                            lcs[i-1][j] : lcs[i][j-1];
                    // Backtrack from the end; insert wins ties.
                    len = 0;
                    i = old_len;
                    j = new_len;
                    while (i > 0 || j > 0) begin
                        if (i > 0 && j > 0 && old_lines[i-1] == new_lines[j-1]) begin
                            ops[len] = OP_EQUAL;
                            ids[len] = old_lines[i-1];
                            i--;
                            j--;
                        end else if (j > 0 && (i == 0 || lcs[i][j-1] >= lcs[i-1][j])) begin
                            ops[len] = OP_INSERT;
                            ids[len] = new_lines[j-1];
                            j--;
                        end else begin
                            ops[len] = OP_DELETE;
                            ids[len] = old_lines[i-1];
                            i--;
                        end
                        len++;
                    end
                    for (int k = len - 1; k >= 0; k--) begin
                        e.op = ops[k];
                        e.line = ids[k];
                        e.run_start = (k == len - 1) || (ops[k] != ops[k+1]);
                        e.last = (k == 0);
                        e.overflow = lines_dropped;
                        script_q = {script_q, e};
                    end
                end
                old_len = 0;
                new_len = 0;
                lines_dropped = 1'b0;
            end
            default: ;
        endcase
    endtask

    // Drive one input transaction and wait for its acceptance.
    task automatic send_item(input logic [1:0] func, input line_id_t id);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= func;
        s_line_id <= id;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_script(func, id);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (script_q.size() != 0) @(posedge aclk);
    endtask

    // Random result stall for the receiver.
    always @(posedge aclk) begin
        m_ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end

    // Compare every accepted result transaction with the oldest expectation.
    always @(posedge aclk) begin
        edit_t want;
        if (aresetn && m_valid && m_ready) begin
            if (script_q.size() == 0) begin
                $error("unexpected result: op %0d line %h", m_op, m_line_out);
                errors++;
            end else begin
                want = script_q.pop_front();
                if (m_op !== want.op) begin
                    $error("op: expected %0d, actual %0d", want.op, m_op);
                    errors++;
                end
                if (m_line_out !== want.line) begin
                    $error("line_out: expected %h, actual %h", want.line, m_line_out);
                    errors++;
                end
                if (m_run_start !== want.run_start) begin
                    $error("run_start: expected %b, actual %b", want.run_start,
                           m_run_start);
                    errors++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %b, actual %b", want.last, m_last);
                    errors++;
                end
                if (m_overflow !== want.overflow) begin
                    $error("overflow: expected %b, actual %b", want.overflow,
                           m_overflow);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("status: fail");
            $finish;
        end
    end

    // Directed stimulus table and random phases.
    initial begin
        stim_row_t r;
        edit_t     chk;
        int        n_old, n_new, phase, sent;
        line_id_t  pool[4];

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty compute right after reset, identical lines, extremes, then
        // an ignored unused function code and a short mixed script.
        add_row(FUNC_COMPUTE, 32'h0, 1'b1, '{OP_EMPTY, '0, 1'b1, 1'b1, 1'b0});
        add_row(FUNC_LOAD_OLD, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(FUNC_LOAD_NEW, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(FUNC_COMPUTE, 32'hFFFF_FFFF, 1'b1,
                '{OP_EQUAL, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0});
        add_row(FUNC_LOAD_NEW, 32'h0, 1'b0, '0);
        add_row(FUNC_COMPUTE, 32'h0, 1'b1, '{OP_INSERT, 32'h0, 1'b1, 1'b1, 1'b0});
        add_row(FUNC_LOAD_OLD, 32'h5555_AAAA, 1'b0, '0);
        add_row(FUNC_COMPUTE, 32'h0, 1'b1,
                '{OP_DELETE, 32'h5555_AAAA, 1'b1, 1'b1, 1'b0});
        add_row(FUNC_NONE, 32'h1234_5678, 1'b0, '0);
        add_row(FUNC_LOAD_OLD, 32'hA, 1'b0, '0);
        add_row(FUNC_LOAD_NEW, 32'hB, 1'b0, '0);
        add_row(FUNC_LOAD_NEW, 32'hA, 1'b0, '0);
        add_row(FUNC_COMPUTE, 32'h0, 1'b0, '0);
        foreach (rows[i]) begin
            r = rows[i];
            send_item(r.func, r.line_id);
            if (r.has_exp) begin
                chk = script_q[$];
                if (chk !== r.exp) begin
                    $error("table row %0d: expected %h, actual %h", i, r.exp, chk);
                    errors++;
                end
            end
        end
        drain();

        // Overflow on both sides: full 32 plus extras, then compute.
        for (int k = 0; k < NLINES + 2; k++) send_item(FUNC_LOAD_OLD, $urandom());
        for (int k = 0; k < NLINES + 1; k++) send_item(FUNC_LOAD_NEW, $urandom());
        send_item(FUNC_COMPUTE, $urandom());
        drain();

        // Random scripts over small alphabets so equal lines are common.
        sent = 0;
        phase = 0;
        while (sent < 40) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            for (int p = 0; p < 4; p++)
                pool[p] = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(3);
            n_old = ($urandom_range(9) == 0) ? $urandom_range(NLINES) : $urandom_range(5);
            n_new = ($urandom_range(9) == 0) ? $urandom_range(NLINES) : $urandom_range(5);
            for (int k = 0; k < n_old + n_new; k++) begin
                if ($urandom_range(1) && n_old > 0) begin
                    send_item(FUNC_LOAD_OLD, pool[$urandom_range(3)]);
                    n_old--;
                end else if (n_new > 0) begin
                    send_item(FUNC_LOAD_NEW, pool[$urandom_range(3)]);
                    n_new--;
                end else begin
                    send_item(FUNC_LOAD_OLD, pool[$urandom_range(3)]);
                    n_old--;
                end
                sent++;
            end
            if ($urandom_range(7) == 0) send_item(FUNC_NONE, $urandom());
            send_item(FUNC_COMPUTE, $urandom());
            sent++;
            if ($urandom_range(5) == 0) drain();
            phase++;
        end

        drain();
        repeat (400) @(posedge aclk);
        done = 1'b1;
        if (errors == 0 && script_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== lcs_line_diff.f =====
hw/rtl/ldiff_pkg.sv
hw/rtl/ldiff_cell.sv
hw/rtl/ldiff_chain.sv
hw/rtl/lcs_line_diff.sv
hw/rtl/ldiff_checker.sv
sim/lcs_line_diff_test.sv
